### rtl/reno_congestion_window_macros.svh
// assertion helpers used by the top-level rtl
`ifndef RENO_CONGESTION_WINDOW_MACROS_SVH
`define RENO_CONGESTION_WINDOW_MACROS_SVH

// same-cycle implication
`define RCW_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rcw assertion failed");

// next-cycle implication
`define RCW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rcw assertion failed");

`endif

### rtl/rcw_pkg.sv
package rcw_pkg;

  localparam int WIN_W       = 32;
  localparam int THR_W       = 16;
  localparam int DUP_W       = 8;
  localparam int ACK_W       = 32;
  localparam int OUT_SEQ_W   = 32;
  localparam int TOTAL_W     = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 144;
  localparam int OUT_PAD_W   = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [WIN_W-1:0] WIN_MAX     = 32'hFFFF_FFFF;
  localparam logic [THR_W-1:0] THR_MAX     = 16'hFFFF;
  localparam logic [THR_W-1:0] THR_RESET   = 16'd256;
  localparam logic [DUP_W-1:0] DUP_MAX     = 8'd255;
  localparam logic [DUP_W-1:0] DUP_RECOVER = 8'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SSTHRESH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 1'b1;

  typedef struct packed {
    logic capture;
    logic eval;
    logic set_thr;
    logic grow_one;
    logic grow_max;
    logic div_start;
    logic add_quot;
    logic load_out;
  } rcw_cmd_t;

  typedef struct packed {
    logic is_round;
    logic dup_hit;
    logic dup_third;
    logic below_thr;
    logic win_zero;
    logic div_busy;
    logic div_done;
  } rcw_status_t;

endpackage

### rtl/rcw_recip.sv
module rcw_recip #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [rcw_pkg::WIN_W-1:0]           divisor_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [2*FRAC_BITS:0]                quot_o
);
  import rcw_pkg::*;

  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(QW + 1);

  logic [WIN_W-1:0] rem_q, rem_d;
  logic [QW-1:0]    quot_q, quot_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             first_q, first_d;

  logic [WIN_W:0]   shifted;
  logic [WIN_W:0]   diff;
  logic             ge;

  // dividend is a single one at bit 2*frac, shifted in first
  assign shifted = {rem_q, first_q};
  assign diff    = shifted - {1'b0, divisor_i};
  assign ge      = shifted >= {1'b0, divisor_i};

  always_comb begin
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    first_d = first_q;
    if (start_i) begin
      rem_d   = '0;
      quot_d  = '0;
      cnt_d   = CW'(QW);
      busy_d  = 1'b1;
      first_d = 1'b1;
    end else if (busy_q) begin
      rem_d   = ge ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
      quot_d  = {quot_q[QW-2:0], ge};
      cnt_d   = cnt_q - CW'(1);
      first_d = 1'b0;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      first_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### rtl/rcw_datapath.sv
module rcw_datapath #(
  parameter int FRAC_BITS = 16,
  parameter int SEQ_BITS  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rcw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rcw_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               kind_i,
  input  logic [rcw_pkg::ACK_W-1:0]          ack_seq_i,
  input  rcw_pkg::rcw_cmd_t                  cmd_i,
  output rcw_pkg::rcw_status_t               status_o,
  output logic [rcw_pkg::OUT_TDATA_W-1:0]    out_data_o
);
  import rcw_pkg::*;

  localparam int QW  = 2 * FRAC_BITS + 1;
  localparam int SW  = ((QW > WIN_W) ? QW : WIN_W) + 1;
  localparam int TW  = THR_W + FRAC_BITS;
  localparam int XW  = (TW > WIN_W) ? TW : WIN_W;
  localparam int IW  = WIN_W - FRAC_BITS;
  localparam int IWX = (IW > THR_W) ? IW : THR_W;
  localparam int DW  = (SEQ_BITS > TOTAL_W) ? SEQ_BITS : TOTAL_W;
  localparam logic [WIN_W-1:0] ONE_FX   = WIN_W'(1) << FRAC_BITS;
  localparam logic [WIN_W-1:0] THREE_FX = WIN_W'(3) << FRAC_BITS;

  logic [WIN_W-1:0]    win_q, win_d;
  logic [THR_W-1:0]    thr_q, thr_d;
  logic [DUP_W-1:0]    cnt_q, cnt_d;
  logic [ACK_W-1:0]    prev_ack_q, prev_ack_d;
  logic                prev_valid_q, prev_valid_d;
  logic [SEQ_BITS-1:0] sp_q, sp_d;
  logic [SEQ_BITS-1:0] rl_q, rl_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                kind_q;
  logic [ACK_W-1:0]    ack_q;
  logic [OUT_TDATA_W-1:0] out_q;

  logic [QW-1:0]    quot;
  logic             div_busy;
  logic             div_done;

  logic [IW-1:0]    win_int;
  logic [IWX-1:0]   win_int_x;
  logic [IWX-1:0]   half_x;
  logic [THR_W-1:0] packets;
  logic [THR_W-1:0] half_sat;
  logic [XW-1:0]    thr_x;
  logic [WIN_W-1:0] thr_sat;
  logic [WIN_W:0]   sum_one;
  logic [WIN_W:0]   sum_recover;
  logic [SW-1:0]    sum_quot;
  logic [WIN_W-1:0] win_one;
  logic [WIN_W-1:0] win_recover;
  logic [WIN_W-1:0] win_quot;
  logic [DUP_W-1:0] cnt_inc;
  logic             dup_hit;
  logic             done_flag;

  rcw_recip #(
    .FRAC_BITS(FRAC_BITS)
  ) u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .divisor_i(win_q),
    .busy_o   (div_busy),
    .done_o   (div_done),
    .quot_o   (quot)
  );

  assign win_int   = win_q[WIN_W-1:FRAC_BITS];
  assign win_int_x = IWX'(win_int);
  assign half_x    = win_int_x >> 1;
  assign packets   = (win_int_x > IWX'(THR_MAX)) ? THR_MAX : win_int_x[THR_W-1:0];
  assign half_sat  = (half_x > IWX'(THR_MAX)) ? THR_MAX : half_x[THR_W-1:0];

  assign thr_x   = XW'(thr_q) << FRAC_BITS;
  assign thr_sat = (thr_x > XW'(WIN_MAX)) ? WIN_MAX : thr_x[WIN_W-1:0];

  assign sum_one     = {1'b0, win_q} + {1'b0, ONE_FX};
  assign sum_recover = {1'b0, win_q >> 1} + {1'b0, THREE_FX};
  assign sum_quot    = SW'(win_q) + SW'(quot);
  assign win_one     = sum_one[WIN_W] ? WIN_MAX : sum_one[WIN_W-1:0];
  assign win_recover = sum_recover[WIN_W] ? WIN_MAX : sum_recover[WIN_W-1:0];
  assign win_quot    = (sum_quot > SW'(WIN_MAX)) ? WIN_MAX : sum_quot[WIN_W-1:0];

  assign cnt_inc   = (cnt_q == DUP_MAX) ? cnt_q : cnt_q + DUP_W'(1);
  assign dup_hit   = prev_valid_q && (prev_ack_q == ack_q);
  assign done_flag = DW'(sp_q) >= DW'(total_q);

  assign status_o.is_round  = kind_q;
  assign status_o.dup_hit   = dup_hit;
  assign status_o.dup_third = dup_hit && (cnt_inc == DUP_RECOVER);
  assign status_o.below_thr = XW'(win_q) < thr_x;
  assign status_o.win_zero  = win_q == '0;
  assign status_o.div_busy  = div_busy;
  assign status_o.div_done  = div_done;

  always_comb begin
    win_d        = win_q;
    thr_d        = thr_q;
    cnt_d        = cnt_q;
    prev_ack_d   = prev_ack_q;
    prev_valid_d = prev_valid_q;
    sp_d         = sp_q;
    rl_d         = rl_q;
    total_d      = total_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INIT_SSTHRESH: thr_d   = cfg_data_i[THR_W-1:0];
        CFG_TOTAL_PACKETS: total_d = cfg_data_i[TOTAL_W-1:0];
        default: ;
      endcase
    end

    if (cmd_i.eval) begin
      if (kind_q) begin
        prev_valid_d = 1'b0;
        rl_d         = sp_q + SEQ_BITS'(win_int);
      end else begin
        sp_d         = SEQ_BITS'($signed(ack_q)) + SEQ_BITS'(1);
        prev_ack_d   = ack_q;
        prev_valid_d = 1'b1;
        if (dup_hit) begin
          cnt_d = cnt_inc;
          if (cnt_inc == DUP_RECOVER) begin
            win_d = win_recover;
          end else if (cnt_inc > DUP_RECOVER) begin
            win_d = win_one;
          end
        end else if (cnt_q != '0) begin
          // leave recovery at the threshold
          cnt_d = '0;
          win_d = thr_sat;
        end
      end
    end

    if (cmd_i.set_thr) thr_d = half_sat;
    if (cmd_i.grow_one) win_d = win_one;
    if (cmd_i.grow_max) win_d = WIN_MAX;
    if (cmd_i.add_quot) win_d = win_quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q        <= ONE_FX;
      thr_q        <= THR_RESET;
      cnt_q        <= '0;
      prev_valid_q <= 1'b0;
      sp_q         <= '0;
      rl_q         <= SEQ_BITS'(1);
      total_q      <= '0;
    end else begin
      win_q        <= win_d;
      thr_q        <= thr_d;
      cnt_q        <= cnt_d;
      prev_valid_q <= prev_valid_d;
      sp_q         <= sp_d;
      rl_q         <= rl_d;
      total_q      <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_ack_q <= prev_ack_d;
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      ack_q  <= ack_seq_i;
    end
    if (cmd_i.load_out) begin
      out_q <= {{OUT_PAD_W{1'b0}}, done_flag, cnt_q, OUT_SEQ_W'(rl_q), OUT_SEQ_W'(sp_q),
                thr_q, packets, win_q};
    end
  end

  assign out_data_o = out_q;

endmodule

### rtl/rcw_ctrl.sv
module rcw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  rcw_pkg::rcw_status_t  status_i,
  output rcw_pkg::rcw_cmd_t     cmd_o
);
  import rcw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_THRESH,
    ST_GROW,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        priority if (status_i.is_round) begin
          state_d = ST_FINISH;
        end else if (status_i.dup_hit) begin
          state_d = status_i.dup_third ? ST_THRESH : ST_FINISH;
        end else begin
          state_d = ST_GROW;
        end
      end
      ST_THRESH: begin
        cmd_o.set_thr = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_GROW: begin
        priority if (status_i.below_thr) begin
          cmd_o.grow_one = 1'b1;
          state_d        = ST_FINISH;
        end else if (status_i.win_zero) begin
          cmd_o.grow_max = 1'b1;
          state_d        = ST_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          cmd_o.add_quot = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

### rtl/reno_congestion_window.sv
// Reno-style congestion window controller. Each input transaction is one event
// (tuser 0: acknowledgement with its sequence in tdata, tuser 1: receive timeout
// that ends the round) and produces exactly one result transaction with the
// window, threshold, send pointer, round limit, duplicate count and done flag.
// Events are handled one at a time; the result sits in an output register, so
// the next event is taken while it waits. After capture, a round end goes
// through evaluate to finish, a duplicate acknowledgement through evaluate and,
// on the third duplicate, the threshold step, a new acknowledgement below the
// threshold or with a zero window through evaluate and grow, and any other new
// acknowledgement also through the one-bit-per-cycle reciprocal divider for 1/cwnd.
// Configuration writes must be made only while no event is in flight; the block
// itself does not enforce it. Writing initial_ssthresh loads the threshold at once.
`include "reno_congestion_window_macros.svh"

module reno_congestion_window #(
  parameter int FRAC_BITS = 16,
  parameter int SEQ_BITS  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rcw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rcw_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // ack_seq[31:0]
  input  logic [rcw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // kind[0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // cwnd_fixed[31:0], cwnd_packets[47:32], slow_start_threshold[63:48],
  // next_sequence[95:64], window_limit[127:96], duplicate_count[135:128],
  // transfer_done[136], zero pad[143:137]
  output logic [rcw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import rcw_pkg::*;

  rcw_cmd_t    cmd;
  rcw_status_t status;

  rcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rcw_datapath #(
    .FRAC_BITS(FRAC_BITS),
    .SEQ_BITS (SEQ_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .kind_i    (s_axis_tuser),
    .ack_seq_i (s_axis_tdata),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_data_o(m_axis_tdata)
  );

  `RCW_ASSERT_NEXT(a_accept_blocks, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `RCW_ASSERT_NOW(a_idle_div_quiet, clk_i, rst_ni, s_axis_tready, !status.div_busy)
  `RCW_ASSERT_NOW(a_load_free, clk_i, rst_ni, cmd.load_out, !m_axis_tvalid || m_axis_tready)

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import rcw_pkg::*;

  localparam logic [WIN_W-1:0] ONE_FIXED = 32'h0001_0000;
  localparam int LIMIT_NS = 30_000_000;

  typedef enum logic {
    EV_ACK   = 1'b0,
    EV_ROUND = 1'b1
  } ev_kind_e;

  typedef struct packed {
    logic [WIN_W-1:0]     cwnd_fixed;
    logic [THR_W-1:0]     cwnd_packets;
    logic [THR_W-1:0]     ssthresh;
    logic [OUT_SEQ_W-1:0] next_seq;
    logic [OUT_SEQ_W-1:0] win_limit;
    logic [DUP_W-1:0]     dup_count;
    logic                 done;
  } window_report_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                    s_axis_tuser = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;

  reno_congestion_window u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // window model state
  logic [WIN_W-1:0]     cwnd;
  logic [THR_W-1:0]     thr;
  logic [DUP_W-1:0]     dups;
  logic [ACK_W-1:0]     last_ack;
  logic                 last_ack_ok;
  logic [OUT_SEQ_W-1:0] snd_ptr;
  logic [OUT_SEQ_W-1:0] rnd_limit;
  logic [TOTAL_W-1:0]   total_pkts;

  window_report_t pending_reports[$];
  window_report_t exp_r;
  window_report_t got_r;
  int             errors = 0;
  bit             src_gaps_on = 1'b1;
  bit             sink_stalls_on = 1'b1;
  int             ready_hold = 0;
  int             stall_pick;
  logic [ACK_W-1:0] ack_base;

  function automatic logic [WIN_W-1:0] sat_add(logic [WIN_W-1:0] a, logic [WIN_W-1:0] b);
    logic [WIN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WIN_W] ? WIN_MAX : s[WIN_W-1:0];
  endfunction

  function automatic window_report_t apply_event(ev_kind_e kind, logic [ACK_W-1:0] ack);
    logic [63:0]      inc;
    logic [WIN_W-1:0] thr_fixed;
    window_report_t   rep;
    if (kind == EV_ACK) begin
      if (last_ack_ok && last_ack == ack) begin
        if (dups != DUP_MAX) dups = dups + 1'b1;
        if (dups == DUP_RECOVER) begin
          cwnd = sat_add(cwnd >> 1, 3 * ONE_FIXED);
          thr = {1'b0, cwnd[WIN_W-1:17]};
        end else if (dups > DUP_RECOVER) begin
          cwnd = sat_add(cwnd, ONE_FIXED);
        end
      end else begin
        thr_fixed = {thr, 16'h0000};
        if (dups != 0) begin
          dups = '0;
          cwnd = thr_fixed;
        end
        if (cwnd < thr_fixed) begin
          cwnd = sat_add(cwnd, ONE_FIXED);
        end else begin
          inc = (cwnd == 0) ? 64'(WIN_MAX) : (64'h1_0000_0000 / 64'(cwnd));
          cwnd = sat_add(cwnd, (inc > 64'(WIN_MAX)) ? WIN_MAX : inc[WIN_W-1:0]);
        end
      end
      snd_ptr = ack + 1'b1;
      last_ack = ack;
      last_ack_ok = 1'b1;
    end else begin
      last_ack_ok = 1'b0;
      rnd_limit = snd_ptr + {16'h0000, cwnd[WIN_W-1:16]};
    end
    rep.cwnd_fixed = cwnd;
    rep.cwnd_packets = cwnd[WIN_W-1:16];
    rep.ssthresh = thr;
    rep.next_seq = snd_ptr;
    rep.win_limit = rnd_limit;
    rep.dup_count = dups;
    rep.done = (snd_ptr >= total_pkts);
    return rep;
  endfunction

  function automatic int pick_gap(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_event(ev_kind_e kind, logic [ACK_W-1:0] ack);
    int gap;
    gap = pick_gap(src_gaps_on);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= ack;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_reports.push_back(apply_event(kind, ack));
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_INIT_SSTHRESH) thr = val[THR_W-1:0];
    else total_pkts = val[TOTAL_W-1:0];
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, seen);
    end
  endtask

  // sink side backpressure
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!sink_stalls_on) begin
      m_axis_tready <= 1'b1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      m_axis_tready <= (stall_pick >= 35);
      ready_hold <= (stall_pick < 4) ? $urandom_range(10, 50) : $urandom_range(0, 3);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t unexpected result transaction: expected none actual %h",
                 $time, m_axis_tdata);
      end else begin
        exp_r = pending_reports.pop_front();
        got_r.cwnd_fixed = m_axis_tdata[31:0];
        got_r.cwnd_packets = m_axis_tdata[47:32];
        got_r.ssthresh = m_axis_tdata[63:48];
        got_r.next_seq = m_axis_tdata[95:64];
        got_r.win_limit = m_axis_tdata[127:96];
        got_r.dup_count = m_axis_tdata[135:128];
        got_r.done = m_axis_tdata[136];
        check_field("cwnd_fixed", exp_r.cwnd_fixed, got_r.cwnd_fixed);
        check_field("cwnd_packets", 32'(exp_r.cwnd_packets), 32'(got_r.cwnd_packets));
        check_field("slow_start_threshold", 32'(exp_r.ssthresh), 32'(got_r.ssthresh));
        check_field("next_sequence", exp_r.next_seq, got_r.next_seq);
        check_field("window_limit", exp_r.win_limit, got_r.win_limit);
        check_field("duplicate_count", 32'(exp_r.dup_count), 32'(got_r.dup_count));
        check_field("transfer_done", 32'(exp_r.done), 32'(got_r.done));
      end
    end
  end

  task automatic test_reset_values();
    // round end straight after reset, an ack with the marker still invalid, then a duplicate of it
    send_event(EV_ROUND, 32'h0000_0000);
    send_event(EV_ACK, 32'h0000_0000);
    send_event(EV_ACK, 32'h0000_0000);
  endtask

  task automatic test_fast_recovery();
    send_event(EV_ACK, 32'd10);
    repeat (5) send_event(EV_ACK, 32'd10);
    send_event(EV_ACK, 32'd11);
    send_event(EV_ROUND, 32'h1234_5678);
    send_event(EV_ACK, 32'd11);
    send_event(EV_ACK, 32'd11);
  endtask

  task automatic test_field_extremes();
    write_cfg(CFG_INIT_SSTHRESH, 32'd1);
    write_cfg(CFG_TOTAL_PACKETS, 32'hFFFF_FFFF);
    send_event(EV_ACK, 32'h7FFF_FFFF);
    send_event(EV_ROUND, 32'h7FFF_FFFF);
    send_event(EV_ACK, 32'hFFFF_FFFF);
    send_event(EV_ROUND, 32'h0000_0000);
    write_cfg(CFG_TOTAL_PACKETS, 32'h0000_0000);
    write_cfg(CFG_INIT_SSTHRESH, 32'd65535);
    send_event(EV_ACK, 32'h0000_0005);
    send_event(EV_ACK, 32'h0000_0006);
    send_event(EV_ROUND, 32'h0000_0000);
  endtask

  task automatic test_near_top_window();
    wait_drain();
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    write_cfg(CFG_INIT_SSTHRESH, 32'd65535);
    // two duplicates then a new ack reloads the window near its top
    send_event(EV_ACK, 32'd100);
    send_event(EV_ACK, 32'd100);
    send_event(EV_ACK, 32'd100);
    send_event(EV_ACK, 32'd101);
    // a duplicate run halves the window and then grows it packet by packet
    repeat (40) send_event(EV_ACK, 32'd101);
    send_event(EV_ROUND, 32'd0);
    send_event(EV_ACK, 32'd102);
    wait_drain();
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  task automatic run_traffic(int n);
    int sent;
    int r;
    int k;
    logic [ACK_W-1:0] ack;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          ack_base = (ack_base + $urandom_range(1, 8)) & 32'h7FFF_FFFF;
          send_event(EV_ACK, ack_base);
          sent++;
        end
        if ($urandom_range(0, 2) == 0) begin
          k = $urandom_range(1, 7);
          repeat (k) begin
            send_event(EV_ACK, ack_base);
            sent++;
          end
          ack_base = (ack_base + $urandom_range(1, 8)) & 32'h7FFF_FFFF;
          send_event(EV_ACK, ack_base);
          sent++;
        end
        send_event(EV_ROUND, $urandom & 32'h7FFF_FFFF);
        sent++;
      end else begin
        case ($urandom_range(0, 3))
          0: ack = ack_base;
          1: ack = 32'hFFFF_FFFF;
          2: ack = $urandom & 32'h7FFF_FFFF;
          default: ack = (ack_base - $urandom_range(0, 4)) & 32'h7FFF_FFFF;
        endcase
        send_event(ev_kind_e'($urandom_range(0, 1)), ack);
        sent++;
      end
      if ($urandom_range(0, 39) == 0) wait_drain();
    end
  endtask

  task automatic test_random_traffic();
    int ph;
    ack_base = $urandom & 32'h7FFF_FFFF;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_cfg(CFG_INIT_SSTHRESH, 32'd1);
          write_cfg(CFG_TOTAL_PACKETS, 32'h0000_0000);
        end
        1: begin
          write_cfg(CFG_INIT_SSTHRESH, 32'd65535);
          write_cfg(CFG_TOTAL_PACKETS, 32'hFFFF_FFFF);
        end
        2: begin
          write_cfg(CFG_INIT_SSTHRESH, $urandom_range(2, 40));
          write_cfg(CFG_TOTAL_PACKETS, ack_base + $urandom_range(0, 200));
        end
        3: begin
          write_cfg(CFG_INIT_SSTHRESH, $urandom_range(1, 65535));
          write_cfg(CFG_TOTAL_PACKETS, $urandom);
        end
        default: begin
          write_cfg(CFG_INIT_SSTHRESH, $urandom_range(4, 16));
          write_cfg(CFG_TOTAL_PACKETS, ack_base + $urandom_range(0, 60));
        end
      endcase
      // one phase runs with no idling on either side
      src_gaps_on = (ph != 2);
      sink_stalls_on = (ph != 2);
      run_traffic(90);
    end
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  initial begin
    cwnd = ONE_FIXED;
    thr = THR_RESET;
    dups = '0;
    last_ack = '0;
    last_ack_ok = 1'b0;
    snd_ptr = '0;
    rnd_limit = 32'd1;
    total_pkts = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_fast_recovery();
    test_field_extremes();
    test_near_top_window();
    test_random_traffic();
    wait_drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
